// ===== src/dwmr_pkg.sv =====
// Shared constants, register codes and multiplier helpers for the two-word modular reducer.
package dwmr_pkg;

   localparam int WORD_W     = 64;
   localparam int HALF_W     = WORD_W / 2;
   localparam int RES_W      = 63;
   localparam int SHIFT_W    = 6;
   localparam int NUM_STAGES = 8;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // register index, taken from paddr[5:3] (8-byte spacing)
   typedef enum logic [2:0] {
      REG_MODULUS         = 3'd0,
      REG_WORD_WEIGHT     = 3'd1,
      REG_WEIGHT_QUOTIENT = 3'd2,
      REG_BARRETT_FACTOR  = 3'd3,
      REG_BARRETT_SHIFT   = 3'd4
   } csr_reg_type;

   localparam logic [RES_W-1:0]   MODULUS_RST = RES_W'(2);
   localparam logic [SHIFT_W-1:0] SHIFT_RST   = SHIFT_W'(1);

   // full 32x32 product
   function automatic logic [WORD_W-1:0] umul32(input logic [HALF_W-1:0] a,
                                                input logic [HALF_W-1:0] b);
      return {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
   endfunction

   // high word of a 64x64 product from its four 32x32 partial products
   function automatic logic [WORD_W-1:0] mul_hi_join(input logic [WORD_W-1:0] ll,
                                                     input logic [WORD_W-1:0] lh,
                                                     input logic [WORD_W-1:0] hl,
                                                     input logic [WORD_W-1:0] hh);
      logic [HALF_W+1:0] mid;
      mid = {2'b00, ll[WORD_W-1:HALF_W]} + {2'b00, lh[HALF_W-1:0]}
          + {2'b00, hl[HALF_W-1:0]};
      return hh + {{HALF_W{1'b0}}, lh[WORD_W-1:HALF_W]}
                + {{HALF_W{1'b0}}, hl[WORD_W-1:HALF_W]}
                + {{(WORD_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};
   endfunction

   // low word of a 64x64 product: low partial plus the low halves of the cross terms
   function automatic logic [WORD_W-1:0] mul_lo_join(input logic [WORD_W-1:0] ll,
                                                     input logic [HALF_W-1:0] cross_a,
                                                     input logic [HALF_W-1:0] cross_b);
      logic [HALF_W-1:0] cross_sum;
      cross_sum = cross_a + cross_b;
      return ll + {cross_sum, {HALF_W{1'b0}}};
   endfunction

endpackage

// ===== src/double_word_modular_reduction_top.sv =====
// Top level: eight-stage pipelined reduction of a 128-bit value modulo a configured n.
//
// Usage:
//  - req channel carries one 128-bit value per transfer: tdata holds the low 64 bits
//    of tdata as high_word and the upper 64 bits as low_word; tlast is last_pair.
//  - rsp channel returns one residue per input, in order; tlast echoes last_pair.
//  - csr port (APB style, 64-bit data, registers at byte offsets 0, 8, 16, 24, 32)
//    holds modulus, word_weight, weight_quotient, barrett_factor, barrett_shift.
//    Write it only while no item is in flight.
// Throughput: one value per cycle while rsp is not stalled. Latency: eight register stages
// (multiply, join, subtract and correction stages: 32x32 partial products, then their sums).
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults (modulus 2, shift 1, others 0).
// When rsp_tready is low the output holds; each stage keeps loading until it is full,
// so bubbles close up and req_tready falls only when the whole pipe is occupied.
module double_word_modular_reduction_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [127:0]                      req_tdata,   // [63:0] high_word, [127:64] low_word
   input  logic                              req_tlast,   // last_pair
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,   // [62:0] residue, [63] zero
   output logic                              rsp_tlast,   // last_result
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dwmr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dwmr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dwmr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import dwmr_pkg::*;

   // ---------------- configuration registers ----------------
   logic [RES_W-1:0]   modulus_ff, modulus_in;
   logic [RES_W-1:0]   weight_ff, weight_in;
   logic [WORD_W-1:0]  wquot_ff, wquot_in;
   logic [WORD_W-1:0]  bfactor_ff, bfactor_in;
   logic [SHIFT_W-1:0] bshift_ff, bshift_in;
   logic               csr_wr;
   csr_reg_type        csr_idx;
   logic [WORD_W-1:0]  n64;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign n64        = {1'b0, modulus_ff};

   always_comb begin
      modulus_in = modulus_ff;
      weight_in  = weight_ff;
      wquot_in   = wquot_ff;
      bfactor_in = bfactor_ff;
      bshift_in  = bshift_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_MODULUS:         modulus_in = csr_pwdata[RES_W-1:0];
            REG_WORD_WEIGHT:     weight_in  = csr_pwdata[RES_W-1:0];
            REG_WEIGHT_QUOTIENT: wquot_in   = csr_pwdata[WORD_W-1:0];
            REG_BARRETT_FACTOR:  bfactor_in = csr_pwdata[WORD_W-1:0];
            REG_BARRETT_SHIFT:   bshift_in  = csr_pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODULUS:         csr_prdata = {1'b0, modulus_ff};
         REG_WORD_WEIGHT:     csr_prdata = {1'b0, weight_ff};
         REG_WEIGHT_QUOTIENT: csr_prdata = wquot_ff;
         REG_BARRETT_FACTOR:  csr_prdata = bfactor_ff;
         REG_BARRETT_SHIFT:   csr_prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, bshift_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RST;
         weight_ff  <= '0;
         wquot_ff   <= '0;
         bfactor_ff <= '0;
         bshift_ff  <= SHIFT_RST;
      end else begin
         modulus_ff <= modulus_in;
         weight_ff  <= weight_in;
         wquot_ff   <= wquot_in;
         bfactor_ff <= bfactor_in;
         bshift_ff  <= bshift_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic [NUM_STAGES-1:0] vld_ff, vld_in, stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      vld_in = {vld_ff[NUM_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

   // ---------------- stage 1: partial products ----------------
   logic [WORD_W-1:0] hw, lw_in0, ww64;
   logic [WORD_W-1:0] a_ll_ff, a_lh_ff, a_hl_ff, a_hh_ff;   // weight_quotient * high
   logic [WORD_W-1:0] a_ll_in, a_lh_in, a_hl_in, a_hh_in;
   logic [WORD_W-1:0] b_ll_ff, b_lh_ff, b_hl_ff, b_hh_ff;   // low * barrett_factor
   logic [WORD_W-1:0] b_ll_in, b_lh_in, b_hl_in, b_hh_in;
   logic [WORD_W-1:0] c_ll_ff, c_ll_in;                     // word_weight * high
   logic [HALF_W-1:0] c_x_ff, c_x_in, c_y_ff, c_y_in;
   logic [WORD_W-1:0] lw1_ff;
   logic [NUM_STAGES-1:0] last_ff;

   assign hw     = req_tdata[WORD_W-1:0];
   assign lw_in0 = req_tdata[2*WORD_W-1:WORD_W];
   assign ww64   = {1'b0, weight_ff};

   always_comb begin
      a_ll_in = umul32(wquot_ff[HALF_W-1:0], hw[HALF_W-1:0]);
      a_lh_in = umul32(wquot_ff[HALF_W-1:0], hw[WORD_W-1:HALF_W]);
      a_hl_in = umul32(wquot_ff[WORD_W-1:HALF_W], hw[HALF_W-1:0]);
      a_hh_in = umul32(wquot_ff[WORD_W-1:HALF_W], hw[WORD_W-1:HALF_W]);
      b_ll_in = umul32(lw_in0[HALF_W-1:0], bfactor_ff[HALF_W-1:0]);
      b_lh_in = umul32(lw_in0[HALF_W-1:0], bfactor_ff[WORD_W-1:HALF_W]);
      b_hl_in = umul32(lw_in0[WORD_W-1:HALF_W], bfactor_ff[HALF_W-1:0]);
      b_hh_in = umul32(lw_in0[WORD_W-1:HALF_W], bfactor_ff[WORD_W-1:HALF_W]);
      c_ll_in = umul32(ww64[HALF_W-1:0], hw[HALF_W-1:0]);
      c_x_in  = HALF_W'(umul32(ww64[HALF_W-1:0], hw[WORD_W-1:HALF_W]));
      c_y_in  = HALF_W'(umul32(ww64[WORD_W-1:HALF_W], hw[HALF_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_ll_ff <= a_ll_in;  a_lh_ff <= a_lh_in;  a_hl_ff <= a_hl_in;  a_hh_ff <= a_hh_in;
         b_ll_ff <= b_ll_in;  b_lh_ff <= b_lh_in;  b_hl_ff <= b_hl_in;  b_hh_ff <= b_hh_in;
         c_ll_ff <= c_ll_in;  c_x_ff  <= c_x_in;   c_y_ff  <= c_y_in;
         lw1_ff  <= lw_in0;
      end
   end

   // last flag rides along every stage
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_en[k]) last_ff[k] <= (k == 0) ? req_tlast : last_ff[(k == 0) ? 0 : k-1];
      end
   end

   // ---------------- stage 2: join products ----------------
   logic [WORD_W-1:0] q1_ff, q1_in, q2raw_ff, q2raw_in, p1_ff, p1_in, lw2_ff;

   always_comb begin
      q1_in    = mul_hi_join(a_ll_ff, a_lh_ff, a_hl_ff, a_hh_ff);
      q2raw_in = mul_hi_join(b_ll_ff, b_lh_ff, b_hl_ff, b_hh_ff);
      p1_in    = mul_lo_join(c_ll_ff, c_x_ff, c_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         q1_ff    <= q1_in;
         q2raw_ff <= q2raw_in;
         p1_ff    <= p1_in;
         lw2_ff   <= lw1_ff;
      end
   end

   // ---------------- stage 3: quotient times modulus, partial products ----------------
   logic [WORD_W-1:0] q2;
   logic [WORD_W-1:0] d_ll_ff, d_ll_in, e_ll_ff, e_ll_in;
   logic [HALF_W-1:0] d_x_ff, d_x_in, d_y_ff, d_y_in, e_x_ff, e_x_in, e_y_ff, e_y_in;
   logic [WORD_W-1:0] p1_3_ff, lw3_ff;

   assign q2 = q2raw_ff >> bshift_ff;

   always_comb begin
      d_ll_in = umul32(q1_ff[HALF_W-1:0], n64[HALF_W-1:0]);
      d_x_in  = HALF_W'(umul32(q1_ff[HALF_W-1:0], n64[WORD_W-1:HALF_W]));
      d_y_in  = HALF_W'(umul32(q1_ff[WORD_W-1:HALF_W], n64[HALF_W-1:0]));
      e_ll_in = umul32(q2[HALF_W-1:0], n64[HALF_W-1:0]);
      e_x_in  = HALF_W'(umul32(q2[HALF_W-1:0], n64[WORD_W-1:HALF_W]));
      e_y_in  = HALF_W'(umul32(q2[WORD_W-1:HALF_W], n64[HALF_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         d_ll_ff <= d_ll_in;  d_x_ff <= d_x_in;  d_y_ff <= d_y_in;
         e_ll_ff <= e_ll_in;  e_x_ff <= e_x_in;  e_y_ff <= e_y_in;
         p1_3_ff <= p1_ff;
         lw3_ff  <= lw2_ff;
      end
   end

   // ---------------- stage 4: join q*n ----------------
   logic [WORD_W-1:0] q1n_ff, q1n_in, q2n_ff, q2n_in, p1_4_ff, lw4_ff;

   assign q1n_in = mul_lo_join(d_ll_ff, d_x_ff, d_y_ff);
   assign q2n_in = mul_lo_join(e_ll_ff, e_x_ff, e_y_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         q1n_ff  <= q1n_in;
         q2n_ff  <= q2n_in;
         p1_4_ff <= p1_3_ff;
         lw4_ff  <= lw3_ff;
      end
   end

   // ---------------- stage 5: raw remainders ----------------
   logic [WORD_W-1:0] r1_ff, r1_in, r2_ff, r2_in;

   assign r1_in = p1_4_ff - q1n_ff;
   assign r2_in = lw4_ff - q2n_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         r1_ff <= r1_in;
         r2_ff <= r2_in;
      end
   end

   // ---------------- stage 6: one correction each ----------------
   logic [WORD_W-1:0] ra_ff, ra_in, rb_ff, rb_in;

   assign ra_in = (r1_ff >= n64) ? r1_ff - n64 : r1_ff;
   assign rb_in = (r2_ff >= n64) ? r2_ff - n64 : r2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         ra_ff <= ra_in;
         rb_ff <= rb_in;
      end
   end

   // ---------------- stage 7: sum (wraps at 64 bits) ----------------
   logic [WORD_W-1:0] sum_ff, sum_in;

   assign sum_in = ra_ff + rb_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) sum_ff <= sum_in;
   end

   // ---------------- stage 8: final correction, output register ----------------
   logic [RES_W-1:0] res_ff, res_in;
   logic [WORD_W-1:0] sum_fix;

   assign sum_fix = (sum_ff >= n64) ? sum_ff - n64 : sum_ff;
   assign res_in  = sum_fix[RES_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[7]) res_ff <= res_in;
   end

   assign rsp_tdata = {1'b0, res_ff};
   assign rsp_tlast = last_ff[NUM_STAGES-1];

endmodule

// ===== src/dwmr_checker.sv =====
// Port-level assertions for the two-word modular reducer, bound to the top level.
module dwmr_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [63:0]                       rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [dwmr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [dwmr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [dwmr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);
   import dwmr_pkg::*;

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // residue stays within 63 bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("residue padding bit set");

   // modulus written is read back, truncated to 63 bits
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[CSR_ADDR_W-1:3] == REG_MODULUS
      ##1 csr_paddr[CSR_ADDR_W-1:3] == REG_MODULUS
      |-> csr_prdata == {1'b0, $past(csr_pwdata[RES_W-1:0])})
      else $error("modulus readback mismatch");

endmodule

bind double_word_modular_reduction_top dwmr_port_checker u_dwmr_checker (.*);
